### sv/blt_pkg.sv
// Package for the blit area-mode word datapath.
// Holds word widths, register indexes, fill codes and the configuration struct.
// No dependencies.
package blt_pkg;

    localparam int WORD_W  = 16;
    localparam int INDEX_W = 3;

    localparam logic [INDEX_W-1:0] REG_MINTERM     = 3'd0;
    localparam logic [INDEX_W-1:0] REG_A_SHIFT     = 3'd1;
    localparam logic [INDEX_W-1:0] REG_B_SHIFT     = 3'd2;
    localparam logic [INDEX_W-1:0] REG_FILL_MODE   = 3'd3;
    localparam logic [INDEX_W-1:0] REG_FILL_CARRY  = 3'd4;
    localparam logic [INDEX_W-1:0] REG_FIRST_MASK  = 3'd5;
    localparam logic [INDEX_W-1:0] REG_LAST_MASK   = 3'd6;

    localparam logic [1:0] FILL_NONE = 2'd0;
    localparam logic [1:0] FILL_INCL = 2'd1;
    localparam logic [1:0] FILL_EXCL = 2'd2;
    localparam logic [1:0] FILL_BOTH = 2'd3;
    localparam int         FILL_EXCL_BIT = 1;

    localparam logic [WORD_W-1:0] MASK_RESET = 16'hFFFF;

    typedef struct packed {
        logic [7:0]        minterm;
        logic [3:0]        a_shift;
        logic [3:0]        b_shift;
        logic [1:0]        fill_mode;
        logic              fill_carry_start;
        logic [WORD_W-1:0] first_mask;
        logic [WORD_W-1:0] last_mask;
    } cfg_t;

endpackage

### sv/blt_cfg_regs.sv
// Configuration register file of the blit word datapath.
// Depends on blt_pkg for register indexes and cfg_t.
module blt_cfg_regs import blt_pkg::*; (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cfg_wr_en,
    input  logic [INDEX_W-1:0] cfg_wr_index,
    input  logic [WORD_W-1:0]  cfg_wr_data,
    output cfg_t               cfg
);

    cfg_t cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.minterm          <= '0;
            cfg_reg.a_shift          <= '0;
            cfg_reg.b_shift          <= '0;
            cfg_reg.fill_mode        <= FILL_NONE;
            cfg_reg.fill_carry_start <= 1'b0;
            cfg_reg.first_mask       <= MASK_RESET;
            cfg_reg.last_mask        <= MASK_RESET;
        end else if (cfg_wr_en) begin
            case (cfg_wr_index)
                REG_MINTERM:    cfg_reg.minterm          <= cfg_wr_data[7:0];
                REG_A_SHIFT:    cfg_reg.a_shift          <= cfg_wr_data[3:0];
                REG_B_SHIFT:    cfg_reg.b_shift          <= cfg_wr_data[3:0];
                REG_FILL_MODE:  cfg_reg.fill_mode        <= cfg_wr_data[1:0];
                REG_FILL_CARRY: cfg_reg.fill_carry_start <= cfg_wr_data[0];
                REG_FIRST_MASK: cfg_reg.first_mask       <= cfg_wr_data;
                REG_LAST_MASK:  cfg_reg.last_mask        <= cfg_wr_data;
                default: ;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

### sv/blt_shift_merge.sv
// Right barrel shifter that borrows low bits of the previous word of the row.
// Depends on blt_pkg for WORD_W.
module blt_shift_merge import blt_pkg::*; (
    input  logic [WORD_W-1:0] prev_word,
    input  logic [WORD_W-1:0] cur_word,
    input  logic [3:0]        shift,
    output logic [WORD_W-1:0] shifted
);

    logic [2*WORD_W-1:0] joined;

    always_comb begin
        joined  = {prev_word, cur_word} >> shift;
        shifted = joined[WORD_W-1:0];
    end

endmodule

### sv/blt_logic_fill.sv
// Minterm logic select followed by the optional inclusive or exclusive fill.
// Depends on blt_pkg for WORD_W and the fill codes.
module blt_logic_fill import blt_pkg::*; (
    input  logic [WORD_W-1:0] a_word,
    input  logic [WORD_W-1:0] b_word,
    input  logic [WORD_W-1:0] c_word,
    input  logic [7:0]        minterm,
    input  logic [1:0]        fill_mode,
    input  logic              carry_in,
    output logic [WORD_W-1:0] dest_word,
    output logic              carry_out
);

    logic [WORD_W-1:0] logic_word;
    logic [WORD_W-1:0] below;
    logic [WORD_W-1:0] pre_carry;

    always_comb begin
        for (int i = 0; i < WORD_W; i++) begin
            logic_word[i] = minterm[{a_word[i], b_word[i], c_word[i]}];
        end
        // carry entering each bit: start carry toggled by every 1 bit below it
        for (int i = 0; i < WORD_W; i++) begin
            below        = (WORD_W'(1) << i) - WORD_W'(1);
            pre_carry[i] = carry_in ^ (^(logic_word & below));
        end
        if (fill_mode == FILL_NONE) begin
            dest_word = logic_word;
            carry_out = carry_in;
        end else if (fill_mode[FILL_EXCL_BIT]) begin
            dest_word = pre_carry ^ logic_word;
            carry_out = carry_in ^ (^logic_word);
        end else begin
            dest_word = pre_carry | logic_word;
            carry_out = carry_in ^ (^logic_word);
        end
    end

endmodule

### sv/blitter_area_word_datapath_unit.sv
// Top level of the blit area-mode word datapath: input register, shift, mask,
// minterm and fill, result register. Depends on blt_pkg, blt_cfg_regs,
// blt_shift_merge and blt_logic_fill.
//
// Takes one item per clock while the result is not stalled by m_ready low, and
// returns one destination word per item: the word is presented on m_valid once
// the item has passed through the input register and then the result register.
// An item is caught in the input register, then the masking, both shifters,
// the minterm select and the 16-bit fill run combinationally into the result
// register. The held A/B words and the fill carry are updated as each item
// moves into the result register, so rows flow without gaps. Configuration
// writes act at once and must be made while idle; the block does not check it.
module blitter_area_word_datapath_unit import blt_pkg::*; (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cfg_wr_en,
    input  logic [INDEX_W-1:0] cfg_wr_index,
    input  logic [WORD_W-1:0]  cfg_wr_data,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [WORD_W-1:0]  s_src_a,
    input  logic [WORD_W-1:0]  s_src_b,
    input  logic [WORD_W-1:0]  s_src_c,
    input  logic               s_row_first,
    input  logic               s_row_last,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [WORD_W-1:0]  m_dest_word
);

    cfg_t cfg;

    logic              in_valid_reg;
    logic [WORD_W-1:0] in_a_reg;
    logic [WORD_W-1:0] in_b_reg;
    logic [WORD_W-1:0] in_c_reg;
    logic              in_first_reg;
    logic              in_last_reg;

    logic              out_valid_reg;
    logic [WORD_W-1:0] out_word_reg;

    logic [WORD_W-1:0] held_a_reg;
    logic [WORD_W-1:0] held_b_reg;
    logic              carry_reg;

    logic              advance;
    logic [WORD_W-1:0] masked_a;
    logic [WORD_W-1:0] prev_a;
    logic [WORD_W-1:0] prev_b;
    logic              carry_start;
    logic [WORD_W-1:0] shifted_a;
    logic [WORD_W-1:0] shifted_b;
    logic [WORD_W-1:0] dest_next;
    logic              carry_next;

    blt_cfg_regs u_cfg (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_index (cfg_wr_index),
        .cfg_wr_data  (cfg_wr_data),
        .cfg          (cfg)
    );

    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;

    always_comb begin
        masked_a = in_a_reg;
        if (in_first_reg) begin
            masked_a = masked_a & cfg.first_mask;
        end
        if (in_last_reg) begin
            masked_a = masked_a & cfg.last_mask;
        end
        prev_a      = in_first_reg ? '0 : held_a_reg;
        prev_b      = in_first_reg ? '0 : held_b_reg;
        carry_start = in_first_reg ? cfg.fill_carry_start : carry_reg;
    end

    blt_shift_merge u_shift_a (
        .prev_word (prev_a),
        .cur_word  (masked_a),
        .shift     (cfg.a_shift),
        .shifted   (shifted_a)
    );

    blt_shift_merge u_shift_b (
        .prev_word (prev_b),
        .cur_word  (in_b_reg),
        .shift     (cfg.b_shift),
        .shifted   (shifted_b)
    );

    blt_logic_fill u_logic (
        .a_word    (shifted_a),
        .b_word    (shifted_b),
        .c_word    (in_c_reg),
        .minterm   (cfg.minterm),
        .fill_mode (cfg.fill_mode),
        .carry_in  (carry_start),
        .dest_word (dest_next),
        .carry_out (carry_next)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            held_a_reg    <= '0;
            held_b_reg    <= '0;
            carry_reg     <= 1'b0;
        end else begin
            if (s_ready) begin
                in_valid_reg <= s_valid;
            end
            if (advance) begin
                out_valid_reg <= 1'b1;
                held_a_reg    <= masked_a;
                held_b_reg    <= in_b_reg;
                carry_reg     <= carry_next;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_a_reg     <= s_src_a;
            in_b_reg     <= s_src_b;
            in_c_reg     <= s_src_c;
            in_first_reg <= s_row_first;
            in_last_reg  <= s_row_last;
        end
        if (advance) begin
            out_word_reg <= dest_next;
        end
    end

    assign m_valid     = out_valid_reg;
    assign m_dest_word = out_word_reg;

    a_result_from_input: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> $past(in_valid_reg))
        else $error("result appeared without a held input item");

    a_stall_holds_input: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> (in_valid_reg && out_valid_reg && !m_ready))
        else $error("input stalled without a blocked result");

    a_row_start_carry: assert property (@(posedge aclk) disable iff (!aresetn)
        (advance && in_first_reg && (cfg.fill_mode == FILL_NONE))
        |=> (carry_reg == $past(cfg.fill_carry_start)))
        else $error("row start did not load the fill carry");

    a_row_start_held_b: assert property (@(posedge aclk) disable iff (!aresetn)
        advance |=> (held_b_reg == $past(in_b_reg)))
        else $error("held B word not taken from the advancing item");

endmodule
